FILE: hw/rtl/owbm_pkg.sv
// Shared types, codes and constants of the 1-Wire bus master.
`timescale 1ns / 1ps

package owbm_pkg;

  // Bits in one byte command
  localparam int unsigned BITS_PER_BYTE = 8;

  // Configuration port geometry
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned IDX_W      = 3;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_RECOVER = 3'd2,
    REG_WRITE_LOW     = 3'd3,
    REG_WRITE_HOLD    = 3'd4,
    REG_READ_LOW      = 3'd5,
    REG_READ_WAIT     = 3'd6,
    REG_READ_HOLD     = 3'd7
  } reg_idx_e;

  // Command codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_RESET      = 3'd0,
    MODE_WRITE_BYTE = 3'd1,
    MODE_READ_BYTE  = 3'd2,
    MODE_WRITE_BIT  = 3'd3,
    MODE_READ_BIT   = 3'd4
  } mode_e;

  // Sequencer phases, one-hot
  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_RST_LOW  = 9'b000000010,
    PH_RST_WAIT = 9'b000000100,
    PH_RST_REC  = 9'b000001000,
    PH_WR_LOW   = 9'b000010000,
    PH_WR_HOLD  = 9'b000100000,
    PH_RD_LOW   = 9'b001000000,
    PH_RD_WAIT  = 9'b010000000,
    PH_RD_HOLD  = 9'b100000000
  } phase_e;

  // Input beat: one timebase tick
  typedef struct packed {
    logic       start_req;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       bus_level;
  } in_item_t;

  // Result beat: one tick of line control and status
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       presence_level;
  } out_item_t;

  // Classified tick handed from front to back
  typedef struct packed {
    logic       go;
    mode_e      mode;
    logic [7:0] tx_byte;
    logic       bus_level;
  } tick_item_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic valid;
  } tq_status_t;

  // Slot timing registers
  typedef struct packed {
    logic [9:0] reset_low;
    logic [7:0] presence_wait;
    logic [9:0] reset_recover;
    logic [5:0] write_low;
    logic [7:0] write_hold;
    logic [5:0] read_low;
    logic [5:0] read_wait;
    logic [7:0] read_hold;
  } cfg_t;

endpackage

FILE: hw/rtl/owbm_front.sv
// Front end: accepts tick beats, decodes the command and queues them.
`timescale 1ns / 1ps

module owbm_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  owbm_pkg::in_item_t    in_data_i,
  output owbm_pkg::tq_status_t  tq_status_o,
  output owbm_pkg::tick_item_t  tq_item_o,
  input  logic                  tq_pop_i
);
  import owbm_pkg::*;

  tick_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  tick_item_t cls;

  // Decode: only modes with a meaning can start a command
  always_comb begin
    cls.go        = in_data_i.start_req && (in_data_i.mode <= MODE_READ_BIT);
    cls.mode      = mode_e'(in_data_i.mode);
    cls.tx_byte   = in_data_i.tx_byte;
    cls.bus_level = in_data_i.bus_level;
  end

  assign full    = (cnt_q == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = tq_pop_i && (cnt_q != 2'd0);

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  assign tq_status_o.valid = (cnt_q != 2'd0);
  assign tq_item_o         = mem_q[rd_ptr_q];

endmodule

FILE: hw/rtl/owbm_seq.sv
// Back end: slot sequencer, one tick per beat, with a two-entry result queue.
`timescale 1ns / 1ps

module owbm_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  owbm_pkg::cfg_t        cfg_i,
  input  owbm_pkg::tq_status_t  tq_status_i,
  input  owbm_pkg::tick_item_t  tq_item_i,
  output logic                  tq_pop_o,
  output logic                  empty,
  input  logic                  pop,
  output owbm_pkg::out_item_t   out_data_o
);
  import owbm_pkg::*;

  phase_e     phase_q, phase_d;
  logic [9:0] tick_q, tick_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] tx_q, tx_d;
  logic [7:0] rx_q, rx_d;
  logic       pres_q, pres_d;
  logic       byte_q, byte_d;
  logic       read_q, read_d;

  out_item_t  oq_q [2];
  logic       owr_q, ord_q;
  logic [1:0] ocnt_q;
  logic       step, opop;
  out_item_t  res;

  // Effective values for this tick, after a possible start
  phase_e     ph;
  logic [9:0] tk;
  logic [2:0] bi;
  logic [7:0] tx;
  logic [7:0] rx;
  logic       is_byte, is_read;
  logic [9:0] len_m1;
  logic       last;
  logic       start;

  // Phase length minus one; a zero register counts as one tick
  function automatic logic [9:0] len_minus1(phase_e p, cfg_t c);
    logic [9:0] v;
    unique case (p)
      PH_RST_LOW:  v = c.reset_low;
      PH_RST_WAIT: v = {2'b00, c.presence_wait};
      PH_RST_REC:  v = c.reset_recover;
      PH_WR_LOW:   v = {4'b0000, c.write_low};
      PH_WR_HOLD:  v = {2'b00, c.write_hold};
      PH_RD_LOW:   v = {4'b0000, c.read_low};
      PH_RD_WAIT:  v = {4'b0000, c.read_wait};
      PH_RD_HOLD:  v = {2'b00, c.read_hold};
      default:     v = 10'd1;
    endcase
    return (v == 10'd0) ? 10'd0 : v - 10'd1;
  endfunction

  // Advance when a tick is queued and the result queue has room
  assign opop     = pop && !empty;
  assign step     = tq_status_i.valid && ((ocnt_q != 2'd2) || opop);
  assign tq_pop_o = step;
  assign start    = (phase_q == PH_IDLE) && tq_item_i.go;

  // Command start overrides the idle state for this tick
  always_comb begin
    if (start) begin
      tk      = 10'd0;
      bi      = 3'd0;
      tx      = tq_item_i.tx_byte;
      rx      = 8'd0;
      is_byte = (tq_item_i.mode == MODE_WRITE_BYTE) || (tq_item_i.mode == MODE_READ_BYTE);
      is_read = (tq_item_i.mode == MODE_READ_BYTE) || (tq_item_i.mode == MODE_READ_BIT);
      if (tq_item_i.mode == MODE_RESET) begin
        ph = PH_RST_LOW;
      end else if (is_read) begin
        ph = PH_RD_LOW;
      end else begin
        ph = PH_WR_LOW;
      end
    end else begin
      ph      = phase_q;
      tk      = tick_q;
      bi      = bit_q;
      tx      = tx_q;
      rx      = rx_q;
      is_byte = byte_q;
      is_read = read_q;
    end
  end

  // One tick of the slot engine
  always_comb begin
    len_m1  = len_minus1(ph, cfg_i);
    last    = (tk >= len_m1);
    phase_d = ph;
    tick_d  = tk;
    bit_d   = bi;
    tx_d    = tx;
    rx_d    = rx;
    pres_d  = pres_q;
    byte_d  = is_byte;
    read_d  = is_read;
    res     = '0;
    if (ph != PH_IDLE) begin
      res.busy_res = 1'b1;
      priority case (1'b1)
        (ph == PH_RST_LOW) || (ph == PH_WR_LOW) || (ph == PH_RD_LOW):
          res.drive_low = 1'b1;
        (ph == PH_WR_HOLD):
          res.drive_low = ~tx[0];
        default:
          res.drive_low = 1'b0;
      endcase
      if (last && (ph == PH_RST_WAIT)) begin
        pres_d = tq_item_i.bus_level;
      end
      if (last && (ph == PH_RD_WAIT) && tq_item_i.bus_level) begin
        rx_d[bi] = 1'b1;
      end
      if (!last) begin
        tick_d = tk + 10'd1;
      end else begin
        tick_d = 10'd0;
        unique case (ph)
          PH_RST_LOW:  phase_d = PH_RST_WAIT;
          PH_RST_WAIT: phase_d = PH_RST_REC;
          PH_WR_LOW:   phase_d = PH_WR_HOLD;
          PH_RD_LOW:   phase_d = PH_RD_WAIT;
          PH_RD_WAIT:  phase_d = PH_RD_HOLD;
          default: begin
            // end of a reset or of a bit slot
            if (is_byte && (({1'b0, bi} + 4'd1) < 4'(BITS_PER_BYTE))) begin
              bit_d   = bi + 3'd1;
              tx_d    = {1'b0, tx[7:1]};
              phase_d = is_read ? PH_RD_LOW : PH_WR_LOW;
            end else begin
              res.done_res = 1'b1;
              res.rx_byte  = is_read ? rx_d : 8'd0;
              phase_d      = PH_IDLE;
            end
          end
        endcase
      end
    end
    res.presence_level = pres_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= 10'd0;
      bit_q   <= 3'd0;
      tx_q    <= 8'd0;
      rx_q    <= 8'd0;
      pres_q  <= 1'b1;
      byte_q  <= 1'b0;
      read_q  <= 1'b0;
    end else if (step) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      pres_q  <= pres_d;
      byte_q  <= byte_d;
      read_q  <= read_d;
    end
  end

  // Result queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (step) begin
        owr_q <= ~owr_q;
      end
      if (opop) begin
        ord_q <= ~ord_q;
      end
      ocnt_q <= ocnt_q + {1'b0, step} - {1'b0, opop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      oq_q[owr_q] <= res;
    end
  end

  assign empty      = (ocnt_q == 2'd0);
  assign out_data_o = oq_q[ord_q];

endmodule

FILE: hw/rtl/one_wire_bus_master.sv
// Top level of the 1-Wire bus master: register file and front/back wiring.
//
//  channel   direction  handshake           beat
//  ticks     in         push / full         in_data_i  (owbm_pkg::in_item_t)
//  results   out        empty / pop         out_data_o (owbm_pkg::out_item_t)
//  config    in         psel/penable/pwrite 32-bit APB, reg i at 4*i
//
// One tick beat is taken per cycle while full is low and yields one result beat; the slot
// counter in the sequencer advances once per beat, which sets the rate.
// An accepted beat is registered in the tick queue and then in the result queue.
// Reset clears the queues, puts the sequencer in idle and loads the
// register defaults. A stalled result side fills the two-entry result
// queue and then the two-entry tick queue before full rises.
`timescale 1ns / 1ps

module one_wire_bus_master (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  owbm_pkg::in_item_t           in_data_i,
  output logic                         empty,
  input  logic                         pop,
  output owbm_pkg::out_item_t          out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [owbm_pkg::ADDR_W-1:0]  paddr,
  input  logic [owbm_pkg::DATA_W-1:0]  pwdata,
  output logic [owbm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import owbm_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  reg_idx_e   idx;
  tq_status_t tq_status;
  tick_item_t tq_item;
  logic       tq_pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low     <= 10'd500;
      cfg_q.presence_wait <= 8'd70;
      cfg_q.reset_recover <= 10'd500;
      cfg_q.write_low     <= 6'd10;
      cfg_q.write_hold    <= 8'd50;
      cfg_q.read_low      <= 6'd5;
      cfg_q.read_wait     <= 6'd5;
      cfg_q.read_hold     <= 8'd50;
    end else if (wr_en) begin
      unique case (idx)
        REG_RESET_LOW:     cfg_q.reset_low     <= pwdata[9:0];
        REG_PRESENCE_WAIT: cfg_q.presence_wait <= pwdata[7:0];
        REG_RESET_RECOVER: cfg_q.reset_recover <= pwdata[9:0];
        REG_WRITE_LOW:     cfg_q.write_low     <= pwdata[5:0];
        REG_WRITE_HOLD:    cfg_q.write_hold    <= pwdata[7:0];
        REG_READ_LOW:      cfg_q.read_low      <= pwdata[5:0];
        REG_READ_WAIT:     cfg_q.read_wait     <= pwdata[5:0];
        REG_READ_HOLD:     cfg_q.read_hold     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (idx)
      REG_RESET_LOW:     prdata = {22'd0, cfg_q.reset_low};
      REG_PRESENCE_WAIT: prdata = {24'd0, cfg_q.presence_wait};
      REG_RESET_RECOVER: prdata = {22'd0, cfg_q.reset_recover};
      REG_WRITE_LOW:     prdata = {26'd0, cfg_q.write_low};
      REG_WRITE_HOLD:    prdata = {24'd0, cfg_q.write_hold};
      REG_READ_LOW:      prdata = {26'd0, cfg_q.read_low};
      REG_READ_WAIT:     prdata = {26'd0, cfg_q.read_wait};
      REG_READ_HOLD:     prdata = {24'd0, cfg_q.read_hold};
      default:           prdata = '0;
    endcase
  end

  owbm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .tq_status_o (tq_status),
    .tq_item_o   (tq_item),
    .tq_pop_i    (tq_pop)
  );

  owbm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .tq_status_i (tq_status),
    .tq_item_i   (tq_item),
    .tq_pop_o    (tq_pop),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hw/rtl/owbm_checker.sv
// Port-level checks of the 1-Wire bus master, bound to the top level.
`timescale 1ns / 1ps

module owbm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 empty,
  input logic                 pop,
  input owbm_pkg::out_item_t  out_data_o
);
  import owbm_pkg::*;

  // A done beat always belongs to a command
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.done_res) |-> out_data_o.busy_res)
    else $error("done without busy");

  // Idle ticks release the line
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_data_o.busy_res) |-> (!out_data_o.drive_low && !out_data_o.done_res))
    else $error("idle tick drives line or signals done");

  // Received data only appears on a done beat
  a_rx_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_data_o.rx_byte != 8'd0)) |-> out_data_o.done_res)
    else $error("rx_byte set outside done");

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("result changed while stalled");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);

FILE: sim/one_wire_bus_master_test.sv
// Self-checking testbench for the 1-Wire bus master: tick stream, slot timing and results.
`timescale 1ns / 1ps

module one_wire_bus_master_test;
  import owbm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 50;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 10;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  in_item_t          tick_beat = '0;
  logic              empty;
  logic              pop = 1'b0;
  out_item_t         line_beat;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  one_wire_bus_master dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_data_i  (tick_beat),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (line_beat),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Pending ticks and expected line states
  in_item_t    tick_q[$];
  out_item_t   expected_line_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // Shadow of the sequencer and its timing registers
  int unsigned slot_len [NUM_REGS];
  phase_e      sq_phase;
  int unsigned sq_ticks;
  logic [2:0]  sq_bit;
  logic [7:0]  sq_tx;
  logic [7:0]  sq_rx;
  logic        sq_presence;
  mode_e       sq_mode;

  function automatic int unsigned reg_width(reg_idx_e idx);
    case (idx)
      REG_RESET_LOW, REG_RESET_RECOVER: return 10;
      REG_WRITE_LOW, REG_READ_LOW, REG_READ_WAIT: return 6;
      default: return 8;
    endcase
  endfunction

  function automatic int unsigned reg_default(reg_idx_e idx);
    case (idx)
      REG_RESET_LOW, REG_RESET_RECOVER: return 500;
      REG_PRESENCE_WAIT: return 70;
      REG_WRITE_LOW: return 10;
      REG_READ_LOW, REG_READ_WAIT: return 5;
      default: return 50;
    endcase
  endfunction

  function automatic int unsigned reg_max(reg_idx_e idx);
    return (1 << reg_width(idx)) - 1;
  endfunction

  // Length of a phase in ticks; a zero register counts as one tick
  function automatic int unsigned slot_ticks(phase_e ph);
    int unsigned v;
    case (ph)
      PH_RST_LOW:  v = slot_len[REG_RESET_LOW];
      PH_RST_WAIT: v = slot_len[REG_PRESENCE_WAIT];
      PH_RST_REC:  v = slot_len[REG_RESET_RECOVER];
      PH_WR_LOW:   v = slot_len[REG_WRITE_LOW];
      PH_WR_HOLD:  v = slot_len[REG_WRITE_HOLD];
      PH_RD_LOW:   v = slot_len[REG_READ_LOW];
      PH_RD_WAIT:  v = slot_len[REG_READ_WAIT];
      PH_RD_HOLD:  v = slot_len[REG_READ_HOLD];
      default:     v = 1;
    endcase
    return (v == 0) ? 1 : v;
  endfunction

  // Advance the shadow sequencer by one tick and give the line state it drives
  function automatic out_item_t step_sequencer(in_item_t t);
    out_item_t r;
    bit        last;
    r = '0;
    if (sq_phase == PH_IDLE && t.start_req && t.mode <= MODE_READ_BIT) begin
      sq_mode  = mode_e'(t.mode);
      sq_tx    = t.tx_byte;
      sq_rx    = '0;
      sq_bit   = '0;
      sq_ticks = 0;
      case (sq_mode)
        MODE_RESET: sq_phase = PH_RST_LOW;
        MODE_WRITE_BYTE, MODE_WRITE_BIT: sq_phase = PH_WR_LOW;
        default: sq_phase = PH_RD_LOW;
      endcase
    end
    if (sq_phase != PH_IDLE) begin
      r.busy_res = 1'b1;
      case (sq_phase)
        PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: r.drive_low = 1'b1;
        PH_WR_HOLD: r.drive_low = ~sq_tx[0];
        default: r.drive_low = 1'b0;
      endcase
      last = (sq_ticks + 1) >= slot_ticks(sq_phase);
      if (last && sq_phase == PH_RST_WAIT) sq_presence = t.bus_level;
      if (last && sq_phase == PH_RD_WAIT && t.bus_level) sq_rx[sq_bit] = 1'b1;
      if (!last) begin
        sq_ticks++;
      end else begin
        sq_ticks = 0;
        case (sq_phase)
          PH_RST_LOW:  sq_phase = PH_RST_WAIT;
          PH_RST_WAIT: sq_phase = PH_RST_REC;
          PH_WR_LOW:   sq_phase = PH_WR_HOLD;
          PH_RD_LOW:   sq_phase = PH_RD_WAIT;
          PH_RD_WAIT:  sq_phase = PH_RD_HOLD;
          default: begin
            // end of a reset or of a bit slot
            if ((sq_mode == MODE_WRITE_BYTE || sq_mode == MODE_READ_BYTE) &&
                int'(sq_bit) + 1 < BITS_PER_BYTE) begin
              sq_bit   = sq_bit + 3'd1;
              sq_tx    = sq_tx >> 1;
              sq_phase = (sq_mode == MODE_WRITE_BYTE) ? PH_WR_LOW : PH_RD_LOW;
            end else begin
              r.done_res = 1'b1;
              if (sq_mode == MODE_READ_BYTE || sq_mode == MODE_READ_BIT) r.rx_byte = sq_rx;
              sq_phase = PH_IDLE;
            end
          end
        endcase
      end
    end
    r.presence_level = sq_presence;
    return r;
  endfunction

  task automatic report(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // Clock and timeout
  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Tick driver: offer the oldest pending tick unless idling this cycle
  always @(negedge clk) begin
    if (rst_n && tick_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
      push      <= 1'b1;
      tick_beat <= tick_q[0];
    end else begin
      push <= 1'b0;
    end
  end

  // Accepted tick beat: predict its line state
  always @(posedge clk) begin
    if (rst_n && push && !full) expected_line_q.push_back(step_sequencer(tick_q.pop_front()));
  end

  // Result side: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      pop       <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Result monitor: compare every popped beat against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && pop && !empty) begin
      if (expected_line_q.size() == 0) begin
        report($sformatf("unexpected result beat %h", line_beat));
      end else begin
        want = expected_line_q.pop_front();
        if (line_beat.drive_low !== want.drive_low || line_beat.busy_res !== want.busy_res ||
            line_beat.done_res !== want.done_res || line_beat.rx_byte !== want.rx_byte ||
            line_beat.presence_level !== want.presence_level)
          report($sformatf({"result mismatch: exp drive %b busy %b done %b rx %h pres %b,",
                            " got drive %b busy %b done %b rx %h pres %b"},
                           want.drive_low, want.busy_res, want.done_res, want.rx_byte,
                           want.presence_level, line_beat.drive_low, line_beat.busy_res,
                           line_beat.done_res, line_beat.rx_byte, line_beat.presence_level));
      end
    end
  end

  // Register access over the APB port
  task automatic reg_read_check(reg_idx_e idx, int unsigned want);
    logic [DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(4 * int'(idx));
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== DATA_W'(want))
      report($sformatf("register %s read: exp %0d got %0d", idx.name(), want, got));
  endtask

  task automatic reg_write(reg_idx_e idx, int unsigned val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    slot_len[idx] = val & reg_max(idx);
    reg_read_check(idx, slot_len[idx]);
  endtask

  // Load every timing register with a value drawn from lo..hi, capped at its width
  task automatic set_timing(int unsigned lo, int unsigned hi);
    int unsigned v;
    for (int i = 0; i < NUM_REGS; i++) begin
      v = $urandom_range(lo, hi);
      if (v > reg_max(reg_idx_e'(i))) v = reg_max(reg_idx_e'(i));
      reg_write(reg_idx_e'(i), v);
    end
  endtask

  task automatic set_idling(int unsigned sender_pct, int unsigned recv_pct);
    sender_idle_pct = sender_pct;
    recv_stall_pct  = recv_pct;
  endtask

  task automatic push_tick(bit start, logic [2:0] mode, logic [7:0] tx, bit bus);
    in_item_t t;
    t.start_req = start;
    t.mode      = mode;
    t.tx_byte   = tx;
    t.bus_level = bus;
    tick_q.push_back(t);
  endtask

  function automatic in_item_t random_tick();
    in_item_t t;
    t.start_req = ($urandom_range(0, 99) < 35);
    t.mode      = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(MODE_READ_BIT + 1, 7))
                                              : 3'($urandom_range(MODE_RESET, MODE_READ_BIT));
    t.tx_byte   = 8'($urandom);
    t.bus_level = 1'($urandom);
    return t;
  endfunction

  task automatic add_random(int unsigned n);
    repeat (n) tick_q.push_back(random_tick());
  endtask

  // One command followed by filler ticks, so that all span exactly as many ticks as it lasts under the current timing;
  // any start in those ticks falls while busy
  task automatic add_cmd(mode_e m, logic [7:0] tx);
    int unsigned len;
    case (m)
      MODE_RESET: len = slot_ticks(PH_RST_LOW) + slot_ticks(PH_RST_WAIT) + slot_ticks(PH_RST_REC);
      MODE_WRITE_BIT: len = slot_ticks(PH_WR_LOW) + slot_ticks(PH_WR_HOLD);
      MODE_WRITE_BYTE: len = BITS_PER_BYTE * (slot_ticks(PH_WR_LOW) + slot_ticks(PH_WR_HOLD));
      MODE_READ_BIT: len = slot_ticks(PH_RD_LOW) + slot_ticks(PH_RD_WAIT) + slot_ticks(PH_RD_HOLD);
      default: len = BITS_PER_BYTE *
                     (slot_ticks(PH_RD_LOW) + slot_ticks(PH_RD_WAIT) + slot_ticks(PH_RD_HOLD));
    endcase
    push_tick(1'b1, m, tx, 1'($urandom));
    repeat (len - 1) tick_q.push_back(random_tick());
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || expected_line_q.size() != 0) @(posedge clk);
  endtask

  // Let any command still running finish before the timing changes
  task automatic settle();
    wait_drained();
    while (sq_phase != PH_IDLE) begin
      repeat (8) push_tick(1'b0, MODE_RESET, 8'($urandom), 1'($urandom));
      wait_drained();
    end
  endtask

  // Sequence of test phases
  initial begin
    for (int i = 0; i < NUM_REGS; i++) slot_len[i] = reg_default(reg_idx_e'(i));
    sq_phase    = PH_IDLE;
    sq_ticks    = 0;
    sq_bit      = '0;
    sq_tx       = '0;
    sq_rx       = '0;
    sq_presence = 1'b1;
    sq_mode     = MODE_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults read back, then short bit commands under them
    for (int i = 0; i < NUM_REGS; i++)
      reg_read_check(reg_idx_e'(i), reg_default(reg_idx_e'(i)));
    add_cmd(MODE_WRITE_BIT, 8'($urandom));
    add_cmd(MODE_READ_BIT, 8'($urandom));
    settle();

    // directed: every phase one tick long
    set_timing(0, 0);
    push_tick(1'b0, MODE_RESET, 8'h00, 1'b1);
    for (int m = MODE_READ_BIT + 1; m <= 7; m++) push_tick(1'b1, 3'(m), 8'hFF, 1'b0);
    push_tick(1'b1, MODE_RESET, 8'h00, 1'b1);
    push_tick(1'b1, MODE_READ_BYTE, 8'hFF, 1'b0);
    push_tick(1'b1, MODE_WRITE_BYTE, 8'h00, 1'b1);
    push_tick(1'b1, MODE_RESET, 8'hFF, 1'b0);
    push_tick(1'b1, MODE_WRITE_BIT, 8'h00, 1'b1);
    push_tick(1'b0, MODE_READ_BIT, 8'hFF, 1'b0);
    push_tick(1'b1, MODE_WRITE_BIT, 8'hFE, 1'b1);
    push_tick(1'b1, MODE_READ_BIT, 8'h01, 1'b0);
    push_tick(1'b1, MODE_WRITE_BIT, 8'h01, 1'b0);
    push_tick(1'b1, MODE_RESET, 8'hFE, 1'b1);
    push_tick(1'b1, MODE_READ_BIT, 8'h55, 1'b0);
    push_tick(1'b1, MODE_WRITE_BYTE, 8'hAA, 1'b1);
    push_tick(1'b0, MODE_RESET, 8'h00, 1'b0);
    push_tick(1'b1, MODE_READ_BIT, 8'h00, 1'b1);
    push_tick(1'b0, MODE_RESET, 8'h00, 1'b0);
    push_tick(1'b1, 3'(MODE_READ_BIT + 1), 8'hFF, 1'b1);
    settle();

    // short slots, no idling, long result hold-off while ticks keep coming
    set_timing(0, 4);
    set_idling(0, 0);
    hold_req++;
    add_random(80);
    settle();

    // minimum nonzero slots, sender mostly idle
    set_timing(1, 1);
    set_idling(79, 0);
    add_random(60);
    settle();

    // receiver mostly stalled, with a full drain in the middle
    set_timing(0, 6);
    set_idling(0, 79);
    add_random(40);
    wait_drained();
    add_random(40);
    settle();

    // wider slots, light idling on both sides
    set_timing(0, 12);
    set_idling(7, 7);
    add_random(80);
    settle();

    // mixed slots to close
    set_timing(2, 8);
    set_idling(7, 7);
    add_random(80);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_line_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
